// File: rtl/bscc_pkg.sv
package bscc_pkg;

   // voltage-to-percent table
   localparam int TABLE_POINTS = 20;
   localparam logic [15:0] OCV_MV [TABLE_POINTS] = '{
      16'd3139, 16'd3220, 16'd3237, 16'd3265, 16'd3290,
      16'd3302, 16'd3304, 16'd3304, 16'd3305, 16'd3306,
      16'd3307, 16'd3312, 16'd3338, 16'd3340, 16'd3342,
      16'd3340, 16'd3341, 16'd3342, 16'd3345, 16'd3352};
   localparam logic [6:0] OCV_PCT [TABLE_POINTS] = '{
      7'd5,  7'd10, 7'd15, 7'd20, 7'd25, 7'd30, 7'd35, 7'd40, 7'd45, 7'd50,
      7'd55, 7'd60, 7'd65, 7'd70, 7'd75, 7'd80, 7'd85, 7'd90, 7'd95, 7'd100};

   localparam logic [6:0]  PCT_FULL         = 7'd100;
   localparam logic [31:0] MA_MS_PER_AH     = 32'd3600000000;
   localparam logic [25:0] MA_MS_PER_PCT_AH = 26'd36000000;
   localparam logic [15:0] CYCLE_MAX        = 16'hFFFF;

   // shared divider geometry
   localparam int NUM_W     = 42;
   localparam int DEN_W     = 36;
   localparam int Q_W       = 7;
   localparam int DIV_STEPS = 7;
   localparam int CNT_W     = $clog2(DIV_STEPS + 1);
   localparam int SEG_NUM_W = 23;

   // item codes
   localparam logic       OP_START      = 1'b0;
   localparam logic       OP_TICK       = 1'b1;
   localparam logic [2:0] MODE_STANDBY  = 3'd0;
   localparam logic [2:0] MODE_CHARGE   = 3'd1;
   localparam logic [2:0] MODE_DISCHRG  = 3'd2;
   localparam logic [2:0] MODE_ERROR    = 3'd3;
   localparam logic [1:0] ERR_OVER_V    = 2'd1;
   localparam logic [1:0] ERR_UNDER_V   = 2'd2;

   // register indexes
   localparam logic CSR_CAPACITY = 1'b0;
   localparam logic CSR_INTERVAL = 1'b1;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic           busy;
      logic           done;
      logic [Q_W-1:0] quot;
   } div_rsp_type;

   typedef struct packed {
      logic                 below;
      logic                 above;
      logic [6:0]           base_pct;
      logic [SEG_NUM_W-1:0] num;
      logic [15:0]          span;
   } ocv_seg_type;

endpackage

// File: rtl/battery_soc_coulomb_counter.sv
// flow: an accepted item passes load, exec and out; a charge or discharge tick also waits
// in divw, a start outside the table passes seed, and an interpolated start divw and seed
// throughput: one item at a time, held up by the 7-step shared divider and by a stalled
// output; an item is taken while a result waits on the output
// reset (synchronous, active high) clears all charge state and sets capacity 100 Ah
// and interval 100 ms
module battery_soc_coulomb_counter import bscc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // input items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // pack_current_ma[20:0], avg_voltage_mv[36:21],
                                    // saved_soc_pct[43:37], zero pad
   input  logic [5:0]  req_tuser,   // operation[0], bms_mode[3:1], error_kind[5:4]
   // result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // soc_pct[6:0], max_soc_pct[13:7], min_soc_pct[20:14],
                                    // cycle_total[36:21], zero pad
   output logic [0:0]  rsp_tuser,   // cycle_done[0]
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [13:0] csr_data
);

   // sequencer states
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_LOAD = 3'd1;
   localparam logic [2:0] ST_EXEC = 3'd2;
   localparam logic [2:0] ST_DIVW = 3'd3;
   localparam logic [2:0] ST_SEED = 3'd4;
   localparam logic [2:0] ST_OUT  = 3'd5;

   logic [2:0]         state_ff,    state_in;
   logic [9:0]         cap_ff;
   logic [13:0]        intv_ff;
   // latched item
   logic               op_ff,       op_in;
   logic [2:0]         mode_ff,     mode_in;
   logic [1:0]         kind_ff,     kind_in;
   logic signed [20:0] cur_ff,      cur_in;
   logic [15:0]        volt_ff,     volt_in;
   logic [6:0]         saved_ff,    saved_in;
   // per-item products
   logic [41:0]        full_ff,     full_in;
   logic [35:0]        unit_ff,     unit_in;
   logic signed [35:0] delta_ff,    delta_in;
   // battery state
   logic [41:0]        charge_ff,   charge_in;
   logic [43:0]        thr_ff,      thr_in;
   logic [6:0]         soc_ff,      soc_in;
   logic [6:0]         high_ff,     high_in;
   logic [6:0]         low_ff,      low_in;
   logic [15:0]        cyc_ff,      cyc_in;
   logic               done_ff,     done_in;
   logic [6:0]         est_ff,      est_in;
   logic               ocv_div_ff,  ocv_div_in;
   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [39:0]        rsp_data_ff,  rsp_data_in;
   logic               rsp_user_ff,  rsp_user_in;

   logic [9:0]         cap_eff;
   logic signed [35:0] cur_x;
   logic signed [35:0] intv_x;
   logic signed [43:0] csum;
   logic [41:0]        c_clamp;
   logic signed [44:0] tsum;
   logic [43:0]        t_clamp;
   logic               cyc_hit;
   logic [6:0]         soc_sel;
   logic [41:0]        seed_prod;

   div_req_type        div_req;
   div_rsp_type        div_rsp;
   ocv_seg_type        seg;

   bscc_ocv u_ocv (
      .volt_mv (volt_ff),
      .seg     (seg)
   );

   bscc_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign req_tready = state_ff == ST_IDLE;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // zero capacity counts as one ampere hour
   assign cap_eff = (cap_ff == 10'd0) ? 10'd1 : cap_ff;
   assign cur_x   = 36'(cur_ff);
   assign intv_x  = 36'(intv_ff);

   // tick math: charge add clamped to 0..full, throughput add or subtract floored at 0
   always_comb begin
      csum = $signed({2'b00, charge_ff}) + 44'(delta_ff);
      if (csum[43]) begin
         c_clamp = '0;
      end else if (csum > $signed({2'b00, full_ff})) begin
         c_clamp = full_ff;
      end else begin
         c_clamp = csum[41:0];
      end
      if (mode_ff == MODE_CHARGE) begin
         tsum = $signed({1'b0, thr_ff}) + 45'(delta_ff);
      end else begin
         tsum = $signed({1'b0, thr_ff}) - 45'(delta_ff);
      end
      t_clamp = tsum[44] ? '0 : tsum[43:0];
      // a battery cycle is counted per two full capacities of throughput
      cyc_hit = {1'b0, t_clamp} >= {2'b00, full_ff, 1'b0};
   end

   // reported percent after a start: saved percent wins unless zero, capped at full
   always_comb begin
      if (saved_ff == 7'd0) begin
         soc_sel = est_ff;
      end else if (saved_ff > PCT_FULL) begin
         soc_sel = PCT_FULL;
      end else begin
         soc_sel = saved_ff;
      end
      seed_prod = 42'(unit_ff) * 42'(soc_sel);
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      mode_in      = mode_ff;
      kind_in      = kind_ff;
      cur_in       = cur_ff;
      volt_in      = volt_ff;
      saved_in     = saved_ff;
      full_in      = full_ff;
      unit_in      = unit_ff;
      delta_in     = delta_ff;
      charge_in    = charge_ff;
      thr_in       = thr_ff;
      soc_in       = soc_ff;
      high_in      = high_ff;
      low_in       = low_ff;
      cyc_in       = cyc_ff;
      done_in      = done_ff;
      est_in       = est_ff;
      ocv_div_in   = ocv_div_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      div_req      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in    = req_tuser[0];
               mode_in  = req_tuser[3:1];
               kind_in  = req_tuser[5:4];
               cur_in   = $signed(req_tdata[20:0]);
               volt_in  = req_tdata[36:21];
               saved_in = req_tdata[43:37];
               done_in  = 1'b0;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            // capacity in mA*ms, one percent of it, and the charge step of this tick
            full_in  = 42'(42'(cap_eff) * 42'(MA_MS_PER_AH));
            unit_in  = 36'(cap_eff) * 36'(MA_MS_PER_PCT_AH);
            delta_in = cur_x * intv_x;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_OUT;
            if (op_ff == OP_START) begin
               if (mode_ff == MODE_STANDBY) begin
                  if (seg.above) begin
                     est_in   = PCT_FULL;
                     state_in = ST_SEED;
                  end else if (seg.below) begin
                     est_in   = 7'd0;
                     state_in = ST_SEED;
                  end else begin
                     // interpolate within the segment on the shared divider
                     div_req.start = 1'b1;
                     div_req.num   = NUM_W'(seg.num);
                     div_req.den   = DEN_W'(seg.span);
                     ocv_div_in    = 1'b1;
                     state_in      = ST_DIVW;
                  end
               end
            end else if (mode_ff == MODE_CHARGE || mode_ff == MODE_DISCHRG) begin
               charge_in = c_clamp;
               if (cyc_hit) begin
                  thr_in  = '0;
                  done_in = 1'b1;
                  if (cyc_ff != CYCLE_MAX) begin
                     cyc_in = cyc_ff + 16'd1;
                  end
               end else begin
                  thr_in = t_clamp;
               end
               // floor percent is charge over one percent of capacity
               div_req.start = 1'b1;
               div_req.num   = c_clamp;
               div_req.den   = unit_ff;
               ocv_div_in    = 1'b0;
               state_in      = ST_DIVW;
            end else if (mode_ff == MODE_ERROR) begin
               if (kind_ff == ERR_OVER_V) begin
                  soc_in    = PCT_FULL;
                  charge_in = full_ff;
                  high_in   = PCT_FULL;
               end else if (kind_ff == ERR_UNDER_V) begin
                  soc_in    = 7'd0;
                  charge_in = '0;
                  low_in    = 7'd0;
               end
            end
         end
         ST_DIVW: begin
            if (div_rsp.done) begin
               if (ocv_div_ff) begin
                  est_in   = seg.base_pct + div_rsp.quot;
                  state_in = ST_SEED;
               end else begin
                  soc_in = div_rsp.quot;
                  if (div_rsp.quot > high_ff) begin
                     high_in = div_rsp.quot;
                  end
                  if (div_rsp.quot < low_ff) begin
                     low_in = div_rsp.quot;
                  end
                  state_in = ST_OUT;
               end
            end
         end
         ST_SEED: begin
            soc_in    = soc_sel;
            high_in   = est_ff;
            low_in    = est_ff;
            cyc_in    = '0;
            charge_in = seed_prod;
            state_in  = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {3'b000, cyc_ff, low_ff, high_ff, soc_ff};
               rsp_user_in  = done_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= 10'd100;
         intv_ff      <= 14'd100;
         charge_ff    <= '0;
         thr_ff       <= '0;
         soc_ff       <= '0;
         high_ff      <= '0;
         low_ff       <= '0;
         cyc_ff       <= '0;
         done_ff      <= 1'b0;
         ocv_div_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         charge_ff    <= charge_in;
         thr_ff       <= thr_in;
         soc_ff       <= soc_in;
         high_ff      <= high_in;
         low_ff       <= low_in;
         cyc_ff       <= cyc_in;
         done_ff      <= done_in;
         ocv_div_ff   <= ocv_div_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_CAPACITY: cap_ff  <= csr_data[9:0];
               CSR_INTERVAL: intv_ff <= csr_data;
               default:      cap_ff  <= cap_ff;
            endcase
         end
      end
      op_ff       <= op_in;
      mode_ff     <= mode_in;
      kind_ff     <= kind_in;
      cur_ff      <= cur_in;
      volt_ff     <= volt_in;
      saved_ff    <= saved_in;
      full_ff     <= full_in;
      unit_ff     <= unit_in;
      delta_ff    <= delta_in;
      est_ff      <= est_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   // reported percent never passes full
   a_soc_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[6:0] <= PCT_FULL)
      else $error("soc above full");

   // divider only finishes while the sequencer waits for it
   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == ST_DIVW)
      else $error("divider result with no waiter");

   // a completed cycle leaves a non-zero count
   a_cycle_cnt: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[36:21] != 16'd0)
      else $error("cycle done with zero count");

   // an accepted item starts the product step next
   a_accept_load: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == ST_LOAD)
      else $error("accepted item not loaded");

endmodule

// File: rtl/bscc_div.sv
module bscc_div import bscc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic [NUM_W-1:0] rem_ff,  rem_in;
   logic [NUM_W-1:0] dsh_ff,  dsh_in;
   logic [Q_W-1:0]   quot_ff, quot_in;
   logic [CNT_W-1:0] cnt_ff,  cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic             sub_ok;

   // restoring divide, one quotient bit a cycle
   always_comb begin
      sub_ok  = rem_ff >= dsh_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in  = req.num;
         dsh_in  = NUM_W'(req.den) << (DIV_STEPS - 1);
         quot_in = '0;
         cnt_in  = CNT_W'(DIV_STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (sub_ok) begin
            rem_in = rem_ff - dsh_ff;
         end
         quot_in = {quot_ff[Q_W-2:0], sub_ok};
         dsh_in  = dsh_ff >> 1;
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quot_ff <= quot_in;
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;

endmodule

// File: rtl/bscc_ocv.sv
module bscc_ocv import bscc_pkg::*; (
   input  logic [15:0] volt_mv,
   output ocv_seg_type seg
);

   logic [15:0] dv;
   logic [6:0]  dp;

   // first table point above the voltage picks the segment
   always_comb begin
      seg.below    = volt_mv < OCV_MV[0];
      seg.above    = volt_mv >= OCV_MV[TABLE_POINTS-1];
      seg.base_pct = '0;
      seg.span     = 16'd1;
      dv           = '0;
      dp           = '0;
      for (int i = TABLE_POINTS - 1; i >= 1; i--) begin
         if (volt_mv < OCV_MV[i]) begin
            seg.base_pct = OCV_PCT[i-1];
            seg.span     = OCV_MV[i] - OCV_MV[i-1];
            dv           = volt_mv - OCV_MV[i-1];
            dp           = OCV_PCT[i] - OCV_PCT[i-1];
         end
      end
      seg.num = SEG_NUM_W'(dv) * SEG_NUM_W'(dp);
   end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import bscc_pkg::*;

   // codes the package leaves out
   localparam logic [2:0] MODE_OTHER = 3'd4;
   localparam logic [2:0] MODE_TOP   = 3'd7;
   localparam logic [1:0] ERR_OTHER  = 2'd0;
   localparam logic [1:0] ERR_SPARE  = 2'd3;

   localparam longint MA_MS_AH     = 64'd3600000000;
   localparam int     STALL_LIMIT  = 2000;   // cycles with no handshake at all
   localparam int     DRAIN_CYCLES = 30;     // well past the longest item latency
   localparam int     PHASE_ITEMS  = 180;
   localparam int     SAT_ITEMS    = 120;    // back-to-back ticks, each completing a cycle
   localparam int     NUM_PHASES   = 6;

   // open-circuit voltage knees, kept apart from the package copy
   localparam int KNEE_N = 20;
   localparam int KNEE_MV [KNEE_N] = '{
      3139, 3220, 3237, 3265, 3290, 3302, 3304, 3304, 3305, 3306,
      3307, 3312, 3338, 3340, 3342, 3340, 3341, 3342, 3345, 3352};
   localparam int KNEE_PCT [KNEE_N] = '{
      5, 10, 15, 20, 25, 30, 35, 40, 45, 50,
      55, 60, 65, 70, 75, 80, 85, 90, 95, 100};

   localparam int EXTREME_MA [4] = '{1048575, -1048576, 0, -1};

   // register settings per random phase: tiny capacity, the shortest interval, zero capacity,
   // the top of both, a capacity write with stray upper bits, then a mid setting
   localparam logic [13:0] PHASE_CAP [NUM_PHASES] = '{
      14'd1, 14'd1000, 14'd0, 14'd1023, 14'h3C07, 14'd40};
   localparam logic [13:0] PHASE_IV [NUM_PHASES] = '{
      14'd10000, 14'd1, 14'd16383, 14'd16383, 14'd2500, 14'd5000};

   typedef struct {
      logic               op;
      logic [2:0]         mode;
      logic [1:0]         kind;
      logic signed [20:0] current_ma;
      logic [15:0]        volt_mv;
      logic [6:0]         saved_pct;
   } gauge_item_type;

   typedef struct packed {
      logic [15:0] cycles;
      logic [6:0]  low;
      logic [6:0]  high;
      logic [6:0]  soc;
      logic        done;
   } soc_report_type;

   typedef struct {
      gauge_item_type item;
      bit             typed;
      soc_report_type want;
   } directed_row_type;

   typedef enum {RX_OPEN, RX_RANDOM, RX_ALTERNATE, RX_BLOCKED} rx_style_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;   // pack_current_ma[20:0], avg_voltage_mv[36:21],
                                  // saved_soc_pct[43:37], zero pad
   logic [5:0]  req_tuser = '0;   // operation[0], bms_mode[3:1], error_kind[5:4]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // soc_pct[6:0], max_soc_pct[13:7], min_soc_pct[20:14],
                                  // cycle_total[36:21], zero pad
   logic [0:0]  rsp_tuser;        // cycle_done[0]
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = 1'b0;
   logic [13:0] csr_data = '0;

   // predictor copy of the registers and the charge state
   logic [9:0]  cfg_capacity = 10'd100;
   logic [13:0] cfg_interval = 14'd100;
   longint      gauge_charge = 0;
   longint      gauge_throughput = 0;
   logic [6:0]  gauge_soc = '0;
   logic [6:0]  gauge_high = '0;
   logic [6:0]  gauge_low = '0;
   logic [15:0] gauge_cycles = '0;

   soc_report_type   soc_expected [$];
   directed_row_type directed_rows [$];

   int  failures = 0;
   int  items_sent = 0;
   int  starts_sent = 0;
   int  flow_ticks = 0;
   int  fault_ticks = 0;
   int  completions = 0;
   int  results_seen = 0;
   int  settings_used = 1;
   bit  saturated = 1'b0;
   bit  steady = 1'b0;     // no sender gaps and no receiver stalls
   int  burst_left = 0;
   int  idle_cycles = 0;
   int  stall_left = 0;
   rx_style_type rx_style = RX_OPEN;
   bit  ready_next;
   soc_report_type got;
   soc_report_type want_r;

   battery_soc_coulomb_counter dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------

   // table lookup with truncating interpolation; the table is not monotonic near
   // the top, so the first knee above the voltage picks the segment
   function automatic logic [6:0] ocv_percent(input logic [15:0] mv);
      int dv;
      int span;
      int dp;
      if (int'(mv) >= KNEE_MV[KNEE_N-1]) return PCT_FULL;
      if (int'(mv) < KNEE_MV[0]) return 7'd0;
      for (int i = 1; i < KNEE_N; i++) begin
         if (int'(mv) < KNEE_MV[i]) begin
            dv   = int'(mv) - KNEE_MV[i-1];
            span = KNEE_MV[i] - KNEE_MV[i-1];
            dp   = KNEE_PCT[i] - KNEE_PCT[i-1];
            return 7'(KNEE_PCT[i-1] + dv * dp / span);
         end
      end
      return PCT_FULL;
   endfunction

   function automatic soc_report_type advance_gauge(input gauge_item_type it);
      longint         full;
      longint         delta;
      longint         level;
      longint         moved;
      logic [6:0]     est;
      soc_report_type r;
      // a zero capacity register reads as one ampere hour
      full = longint'(cfg_capacity == '0 ? 10'd1 : cfg_capacity) * MA_MS_AH;
      r.done = 1'b0;
      if (it.op == OP_START) begin
         // starts outside standby leave everything alone
         if (it.mode == MODE_STANDBY) begin
            est          = ocv_percent(it.volt_mv);
            gauge_high   = est;
            gauge_low    = est;
            gauge_cycles = '0;
            if (it.saved_pct == '0) gauge_soc = est;
            else if (it.saved_pct > PCT_FULL) gauge_soc = PCT_FULL;
            else gauge_soc = it.saved_pct;
            gauge_charge = (full / 100) * longint'(gauge_soc);
         end
      end else if (it.mode == MODE_CHARGE || it.mode == MODE_DISCHRG) begin
         delta = longint'(it.current_ma) * longint'(cfg_interval);
         level = gauge_charge + delta;
         if (level < 0) level = 0;
         if (level > full) level = full;
         gauge_charge = level;
         gauge_soc = 7'((level * 100) / full);
         if (gauge_soc > gauge_high) gauge_high = gauge_soc;
         if (gauge_soc < gauge_low) gauge_low = gauge_soc;
         // throughput against the mode's direction is held at zero
         moved = gauge_throughput + ((it.mode == MODE_CHARGE) ? delta : -delta);
         if (moved < 0) moved = 0;
         if (moved >= 2 * full) begin
            if (gauge_cycles != CYCLE_MAX) gauge_cycles++;
            moved  = 0;
            r.done = 1'b1;
         end
         gauge_throughput = moved;
      end else if (it.mode == MODE_ERROR) begin
         if (it.kind == ERR_OVER_V) begin
            gauge_soc    = PCT_FULL;
            gauge_charge = full;
            gauge_high   = PCT_FULL;
         end else if (it.kind == ERR_UNDER_V) begin
            gauge_soc    = '0;
            gauge_charge = 0;
            gauge_low    = '0;
         end
      end
      r.soc    = gauge_soc;
      r.high   = gauge_high;
      r.low    = gauge_low;
      r.cycles = gauge_cycles;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------

   function automatic void put_row(input logic op, input logic [2:0] mode,
         input logic [1:0] kind, input int cur, input int volt, input int saved,
         input bit typed = 1'b0, input int soc = 0, input int high = 0, input int low = 0);
      directed_row_type row;
      row.item.op         = op;
      row.item.mode       = mode;
      row.item.kind       = kind;
      row.item.current_ma = cur[20:0];
      row.item.volt_mv    = volt[15:0];
      row.item.saved_pct  = saved[6:0];
      row.typed           = typed;
      row.want            = '0;
      row.want.soc        = soc[6:0];
      row.want.high       = high[6:0];
      row.want.low        = low[6:0];
      directed_rows.push_back(row);
   endfunction

   // mostly charge and discharge ticks with the odd start, fault and ignored item
   function automatic gauge_item_type random_item();
      gauge_item_type it;
      int pick;
      int sel;
      pick    = $urandom_range(0, 99);
      it.op   = OP_TICK;
      it.kind = 2'($urandom_range(0, 3));
      it.mode = ($urandom_range(0, 1) == 0) ? MODE_CHARGE : MODE_DISCHRG;
      if (pick < 5) begin
         it.op   = OP_START;
         it.mode = MODE_STANDBY;
      end else if (pick < 8) begin
         it.op   = OP_START;
         it.mode = 3'($urandom_range(MODE_CHARGE, MODE_TOP));
      end else if (pick >= 95) begin
         it.mode = 3'($urandom_range(MODE_OTHER, MODE_TOP));
      end else if (pick >= 90) begin
         it.mode = MODE_STANDBY;
      end else if (pick >= 80) begin
         it.mode = MODE_ERROR;
      end
      sel = $urandom_range(0, 3);
      if (sel == 0) it.current_ma = 21'($urandom);
      else if (sel == 1) it.current_ma = 21'(int'($urandom_range(0, 10000)) - 5000);
      else if (sel == 2) it.current_ma = 21'(int'($urandom_range(0, 400000)) - 200000);
      else it.current_ma = 21'(EXTREME_MA[$urandom_range(0, 3)]);
      it.volt_mv = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                               : 16'($urandom_range(3100, 3400));
      sel = $urandom_range(0, 9);
      if (sel < 5) it.saved_pct = '0;
      else if (sel < 9) it.saved_pct = 7'($urandom_range(1, 100));
      else it.saved_pct = 7'($urandom_range(101, 127));
      return it;
   endfunction

   // hand one item over, with bursts and gaps unless running steady
   task automatic send_item(input gauge_item_type it, input bit typed,
         input soc_report_type want);
      soc_report_type predicted;
      int gap;
      if (!steady && burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         repeat (gap) begin
            @(negedge clock);
            req_tvalid = 1'b0;
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
      end
      if (burst_left > 0) burst_left--;
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = {4'b0, it.saved_pct, it.volt_mv, it.current_ma};
      req_tuser  = {it.kind, it.mode, it.op};
      do @(posedge clock); while (!req_tready);
      predicted = advance_gauge(it);
      soc_expected.push_back(typed ? want : predicted);
      items_sent++;
      if (it.op == OP_START && it.mode == MODE_STANDBY) starts_sent++;
      if (it.op == OP_TICK && (it.mode == MODE_CHARGE || it.mode == MODE_DISCHRG))
         flow_ticks++;
      if (it.op == OP_TICK && it.mode == MODE_ERROR) fault_ticks++;
      if (predicted.done) completions++;
      if (gauge_cycles == CYCLE_MAX) saturated = 1'b1;
   endtask

   // sender holds off until every outstanding result is back
   task automatic drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (soc_expected.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [13:0] value);
      drain();
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_CAPACITY) cfg_capacity = value[9:0];
      else cfg_interval = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic compare_field(input string name, input int want, input int seen);
      if (want != seen) begin
         failures++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, seen);
      end
   endtask

   // ------------------------------------------------------------------
   // receiver stalls: runs of one style, then a fresh one
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (stall_left == 0) begin
         rx_style   = rx_style_type'($urandom_range(0, 3));
         stall_left = $urandom_range(20, 200);
      end
      stall_left--;
      case (rx_style)
         RX_OPEN:      ready_next = 1'b1;
         RX_RANDOM:    ready_next = ($urandom_range(0, 3) != 0);
         RX_ALTERNATE: ready_next = stall_left[0];
         default:      ready_next = (stall_left % 32) >= 24;   // long stalls
      endcase
      rsp_tready = steady | ready_next;
   end

   // ------------------------------------------------------------------
   // result checker: oldest expectation first, every field
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.soc    = rsp_tdata[6:0];
         got.high   = rsp_tdata[13:7];
         got.low    = rsp_tdata[20:14];
         got.cycles = rsp_tdata[36:21];
         got.done   = rsp_tuser[0];
         results_seen++;
         if (soc_expected.size() == 0) begin
            failures++;
            $display("%0t: result with nothing outstanding, expected none, got soc %0d",
                     $time, got.soc);
         end else begin
            want_r = soc_expected.pop_front();
            compare_field("soc_pct", want_r.soc, got.soc);
            compare_field("max_soc_pct", want_r.high, got.high);
            compare_field("min_soc_pct", want_r.low, got.low);
            compare_field("cycle_total", want_r.cycles, got.cycles);
            compare_field("cycle_done", want_r.done, got.done);
         end
      end
   end

   // ------------------------------------------------------------------
   // watchdog: no handshake on any channel for too long ends the run
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
            || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
         $display("watchdog: nothing moved for %0d cycles, %0d results outstanding",
                  STALL_LIMIT, soc_expected.size());
         $display("tb: failure");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin
      gauge_item_type it;

      repeat (8) @(negedge clock);
      reset = 1'b0;

      // directed part, at the reset settings of 100 Ah and 100 ms
      // nothing seeded yet: an ignored tick reports all zero
      put_row(OP_TICK,  MODE_STANDBY, ERR_OTHER, 0, 0, 0, 1'b1, 0, 0, 0);
      // voltage at zero and just under the table: estimate 0
      put_row(OP_START, MODE_STANDBY, ERR_OTHER, 0, 0, 0, 1'b1, 0, 0, 0);
      put_row(OP_START, MODE_STANDBY, ERR_OTHER, 0, 3138, 0, 1'b1, 0, 0, 0);
      // bottom knee exactly
      put_row(OP_START, MODE_STANDBY, ERR_OTHER, 0, 3139, 0, 1'b1, 5, 5, 5);
      // top knee and the top of the field: estimate 100
      put_row(OP_START, MODE_STANDBY, ERR_OTHER, 0, 3352, 0, 1'b1, 100, 100, 100);
      put_row(OP_START, MODE_STANDBY, ERR_OTHER, 0, 65535, 0, 1'b1, 100, 100, 100);
      // inside the non-monotonic stretch of the table
      put_row(OP_START, MODE_STANDBY, ERR_OTHER, 0, 3341, 0);
      // saved percent above 100 is taken as 100; trackers follow the estimate
      put_row(OP_START, MODE_STANDBY, ERR_OTHER, 0, 3220, 127, 1'b1, 100, 10, 10);
      // start outside standby: nothing moves
      put_row(OP_START, MODE_CHARGE, ERR_OTHER, 0, 3139, 0, 1'b1, 100, 10, 10);
      // current extremes both ways in both modes, throughput held at zero
      // when it would run backwards
      put_row(OP_TICK, MODE_CHARGE,  ERR_OTHER, 1048575, 0, 0);
      put_row(OP_TICK, MODE_DISCHRG, ERR_OTHER, -1048576, 0, 0);
      put_row(OP_TICK, MODE_CHARGE,  ERR_OTHER, -1048576, 0, 0);
      put_row(OP_TICK, MODE_DISCHRG, ERR_OTHER, 1048575, 0, 0);
      put_row(OP_TICK, MODE_CHARGE,  ERR_OTHER, -1, 0, 0);
      // fault ticks of every kind
      put_row(OP_TICK, MODE_ERROR, ERR_OTHER, 0, 0, 0);
      put_row(OP_TICK, MODE_ERROR, ERR_OVER_V, 0, 0, 0);
      put_row(OP_TICK, MODE_ERROR, ERR_UNDER_V, 0, 0, 0);
      put_row(OP_TICK, MODE_ERROR, ERR_SPARE, 0, 0, 0);
      // ticks and a start in modes that change nothing
      put_row(OP_TICK, MODE_OTHER, ERR_OTHER, 1048575, 0, 0);
      put_row(OP_TICK, MODE_TOP, ERR_OVER_V, -1048576, 65535, 127);
      put_row(OP_START, MODE_ERROR, ERR_OVER_V, 0, 3300, 50);
      // interpolated start, then a saved percent of one, then a discharge tick
      put_row(OP_START, MODE_STANDBY, ERR_OTHER, 0, 3300, 0);
      put_row(OP_START, MODE_STANDBY, ERR_OTHER, 0, 3342, 1);
      put_row(OP_TICK, MODE_DISCHRG, ERR_OTHER, 123456, 0, 0);

      foreach (directed_rows[i])
         send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

      // random phases, each opened by a start so the ticks act on seeded state
      for (int p = 0; p < NUM_PHASES; p++) begin
         write_csr(CSR_CAPACITY, PHASE_CAP[p]);
         write_csr(CSR_INTERVAL, PHASE_IV[p]);
         settings_used++;
         it = random_item();
         it.op   = OP_START;
         it.mode = MODE_STANDBY;
         send_item(it, 1'b0, '0);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // now and then let the block run dry mid-phase
            if ($urandom_range(0, 149) == 0) drain();
            send_item(random_item(), 1'b0, '0);
         end
      end

      // back-to-back cycle completions: smallest capacity, longest interval,
      // full-scale current swinging both ways so every tick completes a cycle
      write_csr(CSR_CAPACITY, 14'd1);
      write_csr(CSR_INTERVAL, 14'd16383);
      settings_used++;
      steady = 1'b1;
      it = random_item();
      it.op   = OP_START;
      it.mode = MODE_STANDBY;
      send_item(it, 1'b0, '0);
      for (int n = 0; n < SAT_ITEMS; n++) begin
         it.op         = OP_TICK;
         it.mode       = n[0] ? MODE_DISCHRG : MODE_CHARGE;
         it.current_ma = n[0] ? 21'(EXTREME_MA[1]) : 21'(EXTREME_MA[0]);
         send_item(it, 1'b0, '0);
      end
      steady = 1'b0;
      // a few random items on top of the running count, then a clearing start
      for (int n = 0; n < 20; n++) send_item(random_item(), 1'b0, '0);
      it = random_item();
      it.op   = OP_START;
      it.mode = MODE_STANDBY;
      send_item(it, 1'b0, '0);
      send_item(random_item(), 1'b0, '0);

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d items: %0d starts, %0d charge/discharge ticks, %0d fault ticks,",
               items_sent, starts_sent, flow_ticks, fault_ticks);
      $display("%0d register settings, checked %0d results, %0d cycle completions, saturated: %0d",
               settings_used, results_seen, completions, saturated);
      if (failures == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
